// File: src/imutcf_pkg.sv
// ----------------------------------------------------------------------------
// imutcf_pkg
// Shared widths, register indexes and reset values of the tilt filter.
// ----------------------------------------------------------------------------
package imutcf_pkg;

  localparam int SAMPLE_BITS      = 16;   // raw sensor word
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TAB_LEN          = 24;   // entries of the arctangent table
  localparam int TAB_IDX_W        = $clog2(TAB_LEN);

  localparam int TILT_W   = 16;           // Q2.13 radians
  localparam int RATE_W   = 17;           // Q4.12 rad/s
  localparam int NUM_W    = 18;           // offset-corrected accel axis
  localparam int HYP2_W   = 34;           // sum of two squared axes
  localparam int ROOT_W   = HYP2_W / 2;   // floor square root
  localparam int ANG_W    = 27;           // Q.24 radians
  localparam int SUM_W    = 26;           // calibration sums

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_G_COUNTS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND         = 3'd4;

  localparam logic [9:0]  CAL_SAMPLES_RST   = 10'd100;
  localparam logic [14:0] ONE_G_COUNTS_RST  = 15'd16384;
  localparam logic [15:0] GYRO_SCALE_RST    = 16'd4468;
  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd655;
  localparam logic [15:0] BLEND_RST         = 16'd58982;

endpackage

// File: src/imutcf_if.sv
// ----------------------------------------------------------------------------
// imutcf_if
// Valid/ready channels for raw sensor words and filter result words.
// ----------------------------------------------------------------------------
interface imutcf_sample_if;
  logic valid;
  logic ready;
  logic signed [imutcf_pkg::SAMPLE_BITS-1:0] accel_x;
  logic signed [imutcf_pkg::SAMPLE_BITS-1:0] accel_y;
  logic signed [imutcf_pkg::SAMPLE_BITS-1:0] accel_z;
  logic signed [imutcf_pkg::SAMPLE_BITS-1:0] gyro_x;
  logic signed [imutcf_pkg::SAMPLE_BITS-1:0] gyro_y;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  output gyro_x, output gyro_y, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  input gyro_x, input gyro_y, output ready);
endinterface

interface imutcf_result_if;
  logic valid;
  logic ready;
  logic signed [imutcf_pkg::TILT_W-1:0] tilt_x;
  logic signed [imutcf_pkg::TILT_W-1:0] tilt_y;
  logic signed [imutcf_pkg::RATE_W-1:0] x_rate;
  logic signed [imutcf_pkg::RATE_W-1:0] y_rate;
  logic                                 calibrating;

  modport source (output valid, output tilt_x, output tilt_y, output x_rate,
                  output y_rate, output calibrating, input ready);
  modport sink   (input valid, input tilt_x, input tilt_y, input x_rate,
                  input y_rate, input calibrating, output ready);
endinterface

// File: src/imu_tilt_complementary_filter_top.sv
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter_top
// Two-axis complementary tilt filter with offset calibration.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake      | word
//  ---------+-----+----------------+-------------------------------------------
//  sample   | in  | valid / ready  | accel_x, accel_y, accel_z, gyro_x, gyro_y
//  result   | out | valid / ready  | tilt_x, tilt_y, x_rate, y_rate, calibrating
//  cfg      | in  | cfg_write      | cfg_index, cfg_data (no read-back)
//
//  Steps: a calibration word is accepted and then written out; the word that
//  closes calibration runs the restoring divider once for each of the five
//  offsets; a filter word runs one accept step, eight multiplier passes, per
//  axis a square root and CORDIC_STEPS rotations (none on a zero numerator),
//  six blend passes and one output step.
//  Reset clears calibration, offsets and angles and loads register defaults.
//  A finished result waits in the output register; the next sample word is
//  taken meanwhile and holds in the final state only if the result is unread.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter_top #(
  parameter int CORDIC_STEPS = imutcf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [imutcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [imutcf_pkg::CFG_DATA_W-1:0]  cfg_data,
  imutcf_sample_if.sink                      sample,
  imutcf_result_if.source                    result
);
  import imutcf_pkg::*;

  localparam int A_W    = 35;          // wide multiplier operand
  localparam int B_W    = 18;          // narrow multiplier operand
  localparam int PROD_W = A_W + B_W;
  localparam logic [4:0] DIV_LAST = 5'(SUM_W - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_ROOT, S_CORD, S_MUL2, S_DLOAD, S_DIV, S_DONE
  } state_t;

  // Round half away from zero by 2^12, saturate to the rate width.
  function automatic logic signed [RATE_W-1:0] rate_fin(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    q   = (mag + PROD_W'(2048)) >> 12;
    if (v[PROD_W-1]) begin
      rate_fin = (q > PROD_W'(65536)) ? 17'sh10000 : RATE_W'(-q);
    end else begin
      rate_fin = (q > PROD_W'(65535)) ? 17'sh0FFFF : RATE_W'(q);
    end
  endfunction

  // Round half away from zero by 2^31, saturate to the tilt width.
  function automatic logic signed [TILT_W-1:0] tilt_fin(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    q   = (mag + (PROD_W'(1) << 30)) >> 31;
    if (v[PROD_W-1]) begin
      tilt_fin = (q > PROD_W'(32768)) ? 16'sh8000 : TILT_W'(-q);
    end else begin
      tilt_fin = (q > PROD_W'(32767)) ? 16'sh7FFF : TILT_W'(q);
    end
  endfunction

  state_t state;

  // configuration
  logic [9:0]  cal_samples;
  logic [14:0] one_g_counts;
  logic [15:0] gyro_scale;
  logic [15:0] sample_period;
  logic [15:0] blend;

  // calibration
  logic                     cal_done;
  logic [9:0]               sample_count;
  logic signed [SUM_W-1:0]  sum_ax, sum_ay, sum_az, sum_gx, sum_gy;
  logic signed [16:0]       off_ax, off_ay, off_az;
  logic signed [15:0]       off_gx, off_gy;
  logic [9:0]               need;
  logic [10:0]              n_cnt;

  // divider
  logic [2:0]               div_idx;
  logic [9:0]               div_n;
  logic [SUM_W-1:0]         dvd;
  logic [9:0]               rem;
  logic [4:0]               div_cnt;
  logic                     div_neg;
  logic signed [SUM_W-1:0]  div_sum;
  logic [10:0]              div_trial;
  logic                     div_take;
  logic [SUM_W-1:0]         dvd_next;
  logic [9:0]               rem_next;
  logic signed [16:0]       div_q;

  // filter datapath
  logic signed [NUM_W-1:0]  fx, fy, fz;
  logic signed [16:0]       gyd;
  logic signed [17:0]       gxn;
  logic [HYP2_W-1:0]        sq_x, sq_y, sq_z;
  logic signed [RATE_W-1:0] xr, yr;
  logic signed [A_W-1:0]    pred_x, pred_y;
  logic signed [ANG_W-1:0]  acc_x, acc_y;
  logic signed [TILT_W-1:0] angle_x, angle_y;
  logic signed [PROD_W-1:0] mix;
  logic [2:0]               step;
  logic                     axis;
  logic                     item_cal;

  // shared multiplier
  logic signed [A_W-1:0]    mul_a;
  logic signed [B_W-1:0]    mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [B_W-1:0]    gs_op, sp_op, bl_op, nb_op;

  // root and CORDIC units
  logic                     root_start, root_done;
  logic [HYP2_W-1:0]        root_val;
  logic [ROOT_W-1:0]        root_out;
  logic                     cord_start, cord_done;
  logic signed [NUM_W-1:0]  cord_num;
  logic signed [ANG_W-1:0]  cord_ang;

  // output register
  logic                     res_valid;
  logic signed [TILT_W-1:0] res_tilt_x, res_tilt_y;
  logic signed [RATE_W-1:0] res_x_rate, res_y_rate;
  logic                     res_cal;

  assign sample.ready       = (state == S_IDLE);
  assign result.valid       = res_valid;
  assign result.tilt_x      = res_tilt_x;
  assign result.tilt_y      = res_tilt_y;
  assign result.x_rate      = res_x_rate;
  assign result.y_rate      = res_y_rate;
  assign result.calibrating = res_cal;

  assign need  = (cal_samples == '0) ? 10'd1 : cal_samples;
  assign n_cnt = {1'b0, sample_count} + 11'd1;

  assign gs_op = $signed({2'b00, gyro_scale});
  assign sp_op = $signed({2'b00, sample_period});
  assign bl_op = $signed({2'b00, blend});
  assign nb_op = $signed({1'b0, 17'(17'd65536 - {1'b0, blend})});

  assign root_val = axis ? HYP2_W'(sq_x + sq_z) : HYP2_W'(sq_y + sq_z);
  assign cord_num = axis ? fy : fx;

  // Select multiplier operands for the current step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_MUL1) begin
      case (step)
        3'd0: begin mul_a = A_W'(fx);  mul_b = fx;    end
        3'd1: begin mul_a = A_W'(fy);  mul_b = fy;    end
        3'd2: begin mul_a = A_W'(fz);  mul_b = fz;    end
        3'd3: begin mul_a = A_W'(gyd); mul_b = gs_op; end
        3'd4: begin mul_a = A_W'(gxn); mul_b = gs_op; end
        3'd5: begin mul_a = A_W'(xr);  mul_b = sp_op; end
        3'd6: begin mul_a = A_W'(yr);  mul_b = sp_op; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == S_MUL2) begin
      case (step)
        3'd0: begin mul_a = pred_x;                   mul_b = bl_op; end
        3'd1: begin mul_a = A_W'($signed({acc_x, 4'b0})); mul_b = nb_op; end
        3'd2: begin mul_a = pred_y;                   mul_b = bl_op; end
        3'd3: begin mul_a = A_W'($signed({acc_y, 4'b0})); mul_b = nb_op; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // Divider: pick the sum and form one restoring step.
  always_comb begin
    case (div_idx)
      3'd0:    div_sum = sum_ax;
      3'd1:    div_sum = sum_ay;
      3'd2:    div_sum = sum_az;
      3'd3:    div_sum = sum_gx;
      3'd4:    div_sum = sum_gy;
      default: div_sum = '0;
    endcase
    div_trial = {rem, dvd[SUM_W-1]};
    div_take  = (div_trial >= {1'b0, div_n});
    rem_next  = div_take ? 10'(div_trial - {1'b0, div_n}) : div_trial[9:0];
    dvd_next  = {dvd[SUM_W-2:0], div_take};
    div_q     = div_neg ? 17'(-$signed({1'b0, dvd_next[15:0]}))
                        : $signed({1'b0, dvd_next[15:0]});
    if (div_neg && (dvd_next[16:0] == 17'h08000)) begin
      div_q = 17'sh18000;    // average of -32768
    end
  end

  imutcf_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (root_val),
    .done  (root_done),
    .root  (root_out)
  );

  imutcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .num   (cord_num),
    .den   (root_out),
    .done  (cord_done),
    .angle (cord_ang)
  );

  always_ff @(posedge clk) begin
    prod       <= mul_a * mul_b;
    root_start <= 1'b0;
    cord_start <= 1'b0;
    if (rst) begin
      state         <= S_IDLE;
      cal_samples   <= CAL_SAMPLES_RST;
      one_g_counts  <= ONE_G_COUNTS_RST;
      gyro_scale    <= GYRO_SCALE_RST;
      sample_period <= SAMPLE_PERIOD_RST;
      blend         <= BLEND_RST;
      cal_done      <= 1'b0;
      sample_count  <= '0;
      sum_ax <= '0; sum_ay <= '0; sum_az <= '0; sum_gx <= '0; sum_gy <= '0;
      off_ax <= '0; off_ay <= '0; off_az <= '0; off_gx <= '0; off_gy <= '0;
      angle_x   <= '0;
      angle_y   <= '0;
      res_valid <= 1'b0;
      step      <= '0;
      axis      <= 1'b0;
      div_idx   <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_CAL_SAMPLES:   cal_samples   <= cfg_data[9:0];
          CFG_ONE_G_COUNTS:  one_g_counts  <= cfg_data[14:0];
          CFG_GYRO_SCALE:    gyro_scale    <= cfg_data;
          CFG_SAMPLE_PERIOD: sample_period <= cfg_data;
          CFG_BLEND:         blend         <= cfg_data;
          default: ;
        endcase
      end

      // drop the result word once it is taken
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            item_cal <= !cal_done;
            if (!cal_done) begin
              xr     <= '0;
              yr     <= '0;
              sum_ax <= sum_ax + SUM_W'(sample.accel_x);
              sum_ay <= sum_ay + SUM_W'(sample.accel_y);
              sum_az <= sum_az + SUM_W'(sample.accel_z);
              sum_gx <= sum_gx + SUM_W'(sample.gyro_x);
              sum_gy <= sum_gy + SUM_W'(sample.gyro_y);
              if (n_cnt >= {1'b0, need}) begin
                cal_done <= 1'b1;
                div_n    <= n_cnt[9:0];
                div_idx  <= '0;
                state    <= S_DLOAD;
              end else begin
                sample_count <= n_cnt[9:0];
                state        <= S_DONE;
              end
            end else begin
              fx    <= NUM_W'(off_ax) - NUM_W'(sample.accel_x);
              fy    <= NUM_W'(off_ay) - NUM_W'(sample.accel_y);
              fz    <= NUM_W'(sample.accel_z) - NUM_W'(off_az);
              gyd   <= 17'(sample.gyro_y) - 17'(off_gy);
              gxn   <= 18'(off_gx) - 18'(sample.gyro_x);
              step  <= '0;
              state <= S_MUL1;
            end
          end
        end

        S_MUL1: begin
          step <= step + 1'b1;
          case (step)
            3'd1: sq_x <= prod[HYP2_W-1:0];
            3'd2: sq_y <= prod[HYP2_W-1:0];
            3'd3: sq_z <= prod[HYP2_W-1:0];
            3'd4: xr   <= rate_fin(prod);
            3'd5: yr   <= rate_fin(prod);
            3'd6: pred_x <= $signed({{4{angle_x[TILT_W-1]}}, angle_x, 15'b0}) + prod[A_W-1:0];
            3'd7: begin
              pred_y     <= $signed({{4{angle_y[TILT_W-1]}}, angle_y, 15'b0}) + prod[A_W-1:0];
              axis       <= 1'b0;
              root_start <= 1'b1;
              state      <= S_ROOT;
            end
            default: ;
          endcase
        end

        S_ROOT: begin
          if (root_done) begin
            cord_start <= 1'b1;
            state      <= S_CORD;
          end
        end

        S_CORD: begin
          if (cord_done) begin
            if (!axis) begin
              acc_x      <= cord_ang;
              axis       <= 1'b1;
              root_start <= 1'b1;
              state      <= S_ROOT;
            end else begin
              acc_y <= cord_ang;
              step  <= '0;
              state <= S_MUL2;
            end
          end
        end

        S_MUL2: begin
          step <= step + 1'b1;
          case (step)
            3'd1: mix <= prod;
            3'd2: mix <= mix + prod;
            3'd3: begin
              angle_x <= tilt_fin(mix);
              mix     <= prod;
            end
            3'd4: mix <= mix + prod;
            3'd5: begin
              angle_y <= tilt_fin(mix);
              state   <= S_DONE;
            end
            default: ;
          endcase
        end

        S_DLOAD: begin
          div_neg <= div_sum[SUM_W-1];
          dvd     <= (div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum))
                     + SUM_W'(div_n >> 1);
          rem     <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end

        S_DIV: begin
          dvd     <= dvd_next;
          rem     <= rem_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_LAST) begin
            case (div_idx)
              3'd0:    off_ax <= div_q;
              3'd1:    off_ay <= div_q;
              3'd2:    off_az <= div_q - $signed({2'b00, one_g_counts});
              3'd3:    off_gx <= div_q[15:0];
              default: off_gy <= div_q[15:0];
            endcase
            if (div_idx == 3'd4) begin
              state <= S_DONE;
            end else begin
              div_idx <= div_idx + 1'b1;
              state   <= S_DLOAD;
            end
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (!res_valid || result.ready) begin
            res_valid  <= 1'b1;
            res_tilt_x <= angle_x;
            res_tilt_y <= angle_y;
            res_x_rate <= xr;
            res_y_rate <= yr;
            res_cal    <= item_cal;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: src/imutcf_root.sv
// ----------------------------------------------------------------------------
// imutcf_root
// Iterative floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module imutcf_root (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [imutcf_pkg::HYP2_W-1:0]    value,
  output logic                             done,
  output logic [imutcf_pkg::ROOT_W-1:0]    root
);
  import imutcf_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam logic [$clog2(ROOT_W)-1:0] LAST = ($clog2(ROOT_W))'(ROOT_W - 1);

  logic                        busy;
  logic [$clog2(ROOT_W)-1:0]   cnt;
  logic [HYP2_W-1:0]           val;
  logic [REM_W-1:0]            rem;
  logic [REM_W+1:0]            rem_s;
  logic [REM_W+1:0]            trial;
  logic                        take;

  always_comb begin
    rem_s = {rem, val[HYP2_W-1 -: 2]};
    trial = (REM_W+2)'({root, 2'b01});
    take  = (rem_s >= trial);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      val  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val  <= {val[HYP2_W-3:0], 2'b00};
      rem  <= take ? REM_W'(rem_s - trial) : REM_W'(rem_s);
      root <= {root[ROOT_W-2:0], take};
      cnt  <= cnt + 1'b1;
      if (cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// File: src/imutcf_cordic.sv
// ----------------------------------------------------------------------------
// imutcf_cordic
// Vectoring CORDIC: atan2(num, den) for den >= 0, one rotation per cycle.
// ----------------------------------------------------------------------------
module imutcf_cordic #(
  parameter int STEPS = imutcf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [imutcf_pkg::NUM_W-1:0] num,
  input  logic [imutcf_pkg::ROOT_W-1:0]       den,
  output logic                                done,
  output logic signed [imutcf_pkg::ANG_W-1:0] angle
);
  import imutcf_pkg::*;

  localparam int NSTEPS = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;
  localparam logic [TAB_IDX_W-1:0] LAST = TAB_IDX_W'(NSTEPS - 1);
  localparam int XY_W = 38;

  function automatic logic signed [ANG_W-1:0] atan_q24(input logic [TAB_IDX_W-1:0] i);
    case (i)
      5'd0:  atan_q24 = 27'sd13176795;
      5'd1:  atan_q24 = 27'sd7778716;
      5'd2:  atan_q24 = 27'sd4110060;
      5'd3:  atan_q24 = 27'sd2086331;
      5'd4:  atan_q24 = 27'sd1047214;
      5'd5:  atan_q24 = 27'sd524117;
      5'd6:  atan_q24 = 27'sd262123;
      5'd7:  atan_q24 = 27'sd131069;
      5'd8:  atan_q24 = 27'sd65536;
      5'd9:  atan_q24 = 27'sd32768;
      5'd10: atan_q24 = 27'sd16384;
      5'd11: atan_q24 = 27'sd8192;
      5'd12: atan_q24 = 27'sd4096;
      5'd13: atan_q24 = 27'sd2048;
      5'd14: atan_q24 = 27'sd1024;
      5'd15: atan_q24 = 27'sd512;
      5'd16: atan_q24 = 27'sd256;
      5'd17: atan_q24 = 27'sd128;
      5'd18: atan_q24 = 27'sd64;
      5'd19: atan_q24 = 27'sd32;
      5'd20: atan_q24 = 27'sd16;
      5'd21: atan_q24 = 27'sd8;
      5'd22: atan_q24 = 27'sd4;
      5'd23: atan_q24 = 27'sd2;
      default: atan_q24 = '0;
    endcase
  endfunction

  logic                     busy;
  logic [TAB_IDX_W-1:0]     cnt;
  logic signed [XY_W-1:0]   x;
  logic signed [XY_W-1:0]   y;
  logic signed [XY_W-1:0]   sx;
  logic signed [XY_W-1:0]   sy;
  logic signed [ANG_W-1:0]  step_ang;

  always_comb begin
    sx       = x >>> cnt;
    sy       = y >>> cnt;
    step_ang = atan_q24(cnt);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      x     <= XY_W'({den, 16'b0});
      y     <= XY_W'(num) <<< 16;
      angle <= '0;
      cnt   <= '0;
      if (num == '0) begin
        done <= 1'b1;      // zero numerator: angle is exactly zero
      end else begin
        busy <= 1'b1;
      end
    end else if (busy) begin
      if (!y[XY_W-1]) begin
        x     <= x + sy;
        y     <= y - sx;
        angle <= angle + step_ang;
      end else begin
        x     <= x - sy;
        y     <= y + sx;
        angle <= angle - step_ang;
      end
      cnt <= cnt + 1'b1;
      if (cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
